FILE: src/itoa_pkg.sv
// Package for the integer to ASCII formatter: shared types, character constants
// and the digit-to-character function. Depends on nothing.
`default_nettype none
package itoa_pkg;
   localparam int unsigned DIGITS   = 10;
   localparam int unsigned STAGES   = 4;
   localparam int unsigned STEPS    = 8;
   localparam int unsigned BIN_W    = 32;
   localparam int unsigned BCD_W    = 4 * DIGITS;

   localparam logic [6:0] CHAR_ZERO  = 7'h30;
   localparam logic [6:0] CHAR_A     = 7'h41;
   localparam logic [6:0] CHAR_MINUS = 7'h2D;
   localparam logic [3:0] RADIX_DEC  = 4'd10;

   localparam logic FUNC_DEC = 1'b0;
   localparam logic FUNC_HEX = 1'b1;

   typedef struct packed {
      logic              hex;
      logic              neg;
      logic [BIN_W-1:0]  bin;
      logic [BCD_W-1:0]  bcd;
   } work_type;

   function automatic logic [6:0] digit_char(input logic [3:0] d);
      if (d >= RADIX_DEC) begin
         return CHAR_A + {3'b000, d - RADIX_DEC};
      end
      return CHAR_ZERO + {3'b000, d};
   endfunction
endpackage
`default_nettype wire

FILE: src/itoa_dabble_stage.sv
// One pipeline stage of the binary-to-BCD converter: STEPS shift-and-add-3 steps.
// Depends on itoa_pkg.
`default_nettype none
module itoa_dabble_stage (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_valid,
   input  itoa_pkg::work_type    in_data,
   output logic                  in_ready,
   output logic                  out_valid,
   output itoa_pkg::work_type    out_data,
   input  wire                   out_ready
);
   import itoa_pkg::*;

   logic     valid_ff;
   work_type data_ff;
   work_type data_in;

   // Hex items pass through untouched; decimal items take STEPS dabble steps.
   always_comb begin
      logic [BCD_W-1:0] bcd;
      logic [BIN_W-1:0] bin;
      bcd = in_data.bcd;
      bin = in_data.bin;
      for (int s = 0; s < STEPS; s++) begin
         for (int d = 0; d < DIGITS; d++) begin
            if (bcd[4*d +: 4] >= 4'd5) begin
               bcd[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
            end
         end
         bcd = {bcd[BCD_W-2:0], bin[BIN_W-1]};
         bin = {bin[BIN_W-2:0], 1'b0};
      end
      data_in = in_data;
      if (!in_data.hex) begin
         data_in.bcd = bcd;
         data_in.bin = bin;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end
endmodule
`default_nettype wire

FILE: src/itoa_serializer.sv
// Character emitter: holds one converted number and sends its sign and digits.
// Depends on itoa_pkg.
`default_nettype none
module itoa_serializer (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_valid,
   input  itoa_pkg::work_type    in_data,
   output logic                  in_ready,
   output logic                  out_valid,
   output logic [6:0]            out_char,
   output logic                  out_last,
   output logic [3:0]            out_length,
   input  wire                   out_stall
);
   import itoa_pkg::*;

   logic       valid_ff;
   logic       sign_ff;
   logic [3:0] idx_ff;
   logic [3:0] len_ff;
   logic [3:0] digit_ff [DIGITS];
   logic [3:0] ndig;
   logic       take;
   logic       done;

   // Number of significant digits, at least one so that zero prints as "0".
   always_comb begin
      ndig = 4'd1;
      for (int i = 1; i < DIGITS; i++) begin
         if (in_data.bcd[4*i +: 4] != 4'd0) begin
            ndig = 4'(i + 1);
         end
      end
   end

   assign take       = valid_ff && !out_stall;
   assign done       = take && !sign_ff && (idx_ff == 4'd0);
   assign in_ready   = !valid_ff || done;
   assign out_valid  = valid_ff;
   assign out_char   = sign_ff ? CHAR_MINUS : digit_char(digit_ff[idx_ff]);
   assign out_last   = !sign_ff && (idx_ff == 4'd0);
   assign out_length = len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sign_ff  <= 1'b0;
         idx_ff   <= 4'd0;
         len_ff   <= 4'd0;
      end else if (in_ready && in_valid) begin
         valid_ff <= 1'b1;
         sign_ff  <= in_data.neg;
         idx_ff   <= ndig - 4'd1;
         len_ff   <= ndig + {3'b000, in_data.neg};
      end else if (done) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         if (sign_ff) begin
            sign_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff - 4'd1;
         end
      end
      if (in_ready && in_valid) begin
         for (int i = 0; i < DIGITS; i++) begin
            digit_ff[i] <= in_data.bcd[4*i +: 4];
         end
      end
   end
endmodule
`default_nettype wire

FILE: src/integer_to_ascii_formatter.sv
// Integer to ASCII formatter, top level. Depends on itoa_pkg, itoa_dabble_stage
// and itoa_serializer.
// The request is registered in stage zero, in each of the four converter stages
// and in the character emitter before its first character is shown.
// Throughput: one character per cycle while rsp_stall is low; a number's text is
// 1 to 11 characters long, and the character emitter in the last stage sets the rate.
// Reset: synchronous, active high; all valid bits clear and nothing is emitted.
`default_nettype none
module integer_to_ascii_formatter (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_stall,
   input  wire  [31:0]  req_value,
   input  wire          req_func,
   output logic         rsp_valid,
   input  wire          rsp_stall,
   output logic [6:0]   rsp_char_code,
   output logic         rsp_last,
   output logic [3:0]   rsp_text_length
);
   import itoa_pkg::*;

   // Stage zero registers the request with the magnitude already taken.
   // In decimal mode a negative value is negated as an unsigned word, so the
   // most negative value gives 2147483648. In hex mode the raw word is loaded
   // straight into the digit field and the converter stages leave it alone.
   logic     s0_valid_ff;
   work_type s0_data_ff;
   work_type s0_data_in;
   logic     s0_ready;

   logic     stage_valid [STAGES+1];
   work_type stage_data  [STAGES+1];
   logic     stage_ready [STAGES+1];

   always_comb begin
      logic [BIN_W-1:0] mag;
      s0_data_in.hex = (req_func == FUNC_HEX);
      s0_data_in.neg = (req_func == FUNC_DEC) && req_value[31];
      mag = s0_data_in.neg ? (32'd0 - req_value) : req_value;
      s0_data_in.bin = mag;
      s0_data_in.bcd = s0_data_in.hex ? {{(BCD_W-BIN_W){1'b0}}, mag} : '0;
   end

   assign s0_ready  = !s0_valid_ff || stage_ready[0];
   assign req_stall = !s0_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_ready) begin
         s0_valid_ff <= req_valid;
      end
      if (s0_ready && req_valid) begin
         s0_data_ff <= s0_data_in;
      end
   end

   assign stage_valid[0] = s0_valid_ff;
   assign stage_data[0]  = s0_data_ff;

   // Four converter stages of eight double-dabble steps each cover all 32 bits.
   for (genvar g = 0; g < STAGES; g++) begin : g_dabble
      itoa_dabble_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[g]),
         .in_data   (stage_data[g]),
         .in_ready  (stage_ready[g]),
         .out_valid (stage_valid[g+1]),
         .out_data  (stage_data[g+1]),
         .out_ready (stage_ready[g+1])
      );
   end

   // The emitter takes a new number when it is empty or as its last character leaves.
   itoa_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (stage_valid[STAGES]),
      .in_data    (stage_data[STAGES]),
      .in_ready   (stage_ready[STAGES]),
      .out_valid  (rsp_valid),
      .out_char   (rsp_char_code),
      .out_last   (rsp_last),
      .out_length (rsp_text_length),
      .out_stall  (rsp_stall)
   );
endmodule
`default_nettype wire

FILE: src/itoa_checker.sv
// Port-level checker for the integer to ASCII formatter, with its bind.
// Depends on itoa_pkg and integer_to_ascii_formatter.
`default_nettype none
module itoa_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire [6:0]  rsp_char_code,
   input wire        rsp_last,
   input wire [3:0]  rsp_text_length
);
   import itoa_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_char_code)
         && $stable(rsp_last) && $stable(rsp_text_length))
      else $error("stalled response changed");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_text_length >= 4'd1 && rsp_text_length <= 4'd11)
      else $error("text length out of range");

   a_len_same: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=>
         rsp_valid && rsp_text_length == $past(rsp_text_length))
      else $error("text length changed within a number");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last && rsp_text_length == 4'd1 |-> rsp_char_code != CHAR_MINUS)
      else $error("lone character is a minus sign");
endmodule

bind integer_to_ascii_formatter itoa_checker u_itoa_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_char_code   (rsp_char_code),
   .rsp_last        (rsp_last),
   .rsp_text_length (rsp_text_length)
);
`default_nettype wire

FILE: tb/integer_to_ascii_formatter_test.sv
// Testbench for the integer to ASCII formatter: drives numbers in both bases,
// predicts the character stream and checks every character. Depends on itoa_pkg.
`default_nettype none

// Scoreboard that turns each accepted number into its expected characters
// and compares the characters that the block emits, oldest first.
class text_scoreboard;
   typedef struct packed {
      logic [6:0] char_code;
      logic       last;
      logic [3:0] text_length;
   } char_item_type;

   char_item_type pending_chars[$];
   int            error_count;

   function void note_number(logic [31:0] value, logic func);
      logic [3:0]    digits [10];
      logic [31:0]   mag;
      logic [31:0]   radix;
      logic          neg;
      int            total;
      logic [3:0]    len;
      char_item_type item;
      neg = (func == itoa_pkg::FUNC_DEC) && value[31];
      mag = neg ? (32'd0 - value) : value;
      radix = (func == itoa_pkg::FUNC_HEX) ? 32'd16 : 32'd10;
      total = 0;
      if (mag == 0) begin
         digits[0] = 4'd0;
         total = 1;
      end
      while (mag != 0 && total < 10) begin
         digits[total] = 4'(mag % radix);
         mag = mag / radix;
         total++;
      end
      len = 4'(total + neg);
      if (neg) begin
         item = '{itoa_pkg::CHAR_MINUS, 1'b0, len};
         pending_chars.push_back(item);
      end
      for (int i = total - 1; i >= 0; i--) begin
         item.char_code = (digits[i] >= 10) ?
            itoa_pkg::CHAR_A + 7'(digits[i] - 10) : itoa_pkg::CHAR_ZERO + 7'(digits[i]);
         item.last = (i == 0);
         item.text_length = len;
         pending_chars.push_back(item);
      end
   endfunction

   function void check_char(logic [6:0] char_code, logic last, logic [3:0] text_length);
      char_item_type want;
      if (pending_chars.size() == 0) begin
         $display("%0t: unexpected character: expected none, actual %h last %b len %0d",
                  $time, char_code, last, text_length);
         error_count++;
         return;
      end
      want = pending_chars.pop_front();
      if (char_code !== want.char_code) begin
         $display("%0t: char_code mismatch: expected %h, actual %h",
                  $time, want.char_code, char_code);
         error_count++;
      end
      if (last !== want.last) begin
         $display("%0t: last mismatch: expected %b, actual %b", $time, want.last, last);
         error_count++;
      end
      if (text_length !== want.text_length) begin
         $display("%0t: text_length mismatch: expected %0d, actual %0d",
                  $time, want.text_length, text_length);
         error_count++;
      end
   endfunction
endclass

module integer_to_ascii_formatter_test;
   import itoa_pkg::*;

   localparam int RANDOM_NUMBERS = 150;
   localparam int WATCHDOG_LIMIT = 2000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_value;
   logic        req_func;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [6:0]  rsp_char_code;
   logic        rsp_last;
   logic [3:0]  rsp_text_length;

   text_scoreboard expected_text;
   bit             sending_done;
   int             idle_cycles;

   integer_to_ascii_formatter u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_value(req_value), .req_func(req_func),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_char_code(rsp_char_code), .rsp_last(rsp_last),
      .rsp_text_length(rsp_text_length)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Inputs start known; reset is held high at the start and released once.
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_value = '0;
      req_func = FUNC_DEC;
      rsp_stall = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // Sends one number. The gap before it is drawn per transaction, and valid
   // is only lowered when a gap actually follows, so back-to-back numbers keep
   // valid high without a second assignment in the same step.
   task automatic send_number(logic [31:0] value, logic func);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      req_func <= func;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // The handshake completed at this edge; record the number right away.
      expected_text.note_number(value, func);
   endtask

   // Random values lean toward short and boundary numbers so that every text
   // length appears, while full 32-bit words keep every bit toggling.
   function automatic logic [31:0] random_value();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 9);
         1: return -$urandom_range(0, 1000);
         2: return $urandom >> $urandom_range(0, 31);
         3: return {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   // Stimulus: a directed set of boundary numbers, then random numbers with
   // one pause that lets the whole pipeline drain.
   initial begin
      logic [31:0] directed [];
      directed = '{32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                   32'd9, 32'd10, 32'd15, 32'd16, 32'd1_000_000_000,
                   32'hFEDC_BA98, 32'h1234_5678, 32'hAAAA_AAAA,
                   32'h5555_5555};
      expected_text = new();
      sending_done = 1'b0;
      @(negedge reset);
      @(posedge clock);
      foreach (directed[i]) begin
         send_number(directed[i], FUNC_DEC);
         send_number(directed[i], FUNC_HEX);
      end
      for (int n = 0; n < RANDOM_NUMBERS; n++) begin
         if (n == RANDOM_NUMBERS / 2) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (expected_text.pending_chars.size() != 0) @(posedge clock);
         end
         send_number(random_value(), 1'($urandom_range(0, 1)));
      end
      req_valid <= 1'b0;
      sending_done = 1'b1;
   end

   // Receiver: stalls for a random number of cycles before each character,
   // with frequent runs of no stall at all.
   initial begin
      int hold;
      @(negedge reset);
      forever begin
         hold = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 15);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Checks each character at the edge where it is accepted.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         expected_text.check_char(rsp_char_code, rsp_last, rsp_text_length);
      end
   end

   // Watchdog: counts cycles without any transaction on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // End of run: drain, let the pipeline settle, then report once.
   initial begin
      @(negedge reset);
      while (!(sending_done && expected_text.pending_chars.size() == 0)
             && idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
      end else begin
         repeat (40) @(posedge clock);
         if (expected_text.error_count == 0 && expected_text.pending_chars.size() == 0) begin
            $display("Testbench completed without errors");
         end else begin
            $display("Testbench completed WITH ERRORS");
         end
      end
      $finish;
   end
endmodule
`default_nettype wire

FILE: files.f
src/itoa_pkg.sv
src/itoa_dabble_stage.sv
src/itoa_serializer.sv
src/integer_to_ascii_formatter.sv
src/itoa_checker.sv
tb/integer_to_ascii_formatter_test.sv
